// ===== sv/pcc_pkg.sv =====
// types, constants and the nucleotide decoder shared by the consensus caller
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned CNT_W     = 9;
	localparam int unsigned GAP_W     = 12;
	localparam int unsigned NUM_BASES = 4;
	localparam int unsigned OUT_W     = 2 + GAP_W + CNT_W + CNT_W;

	// called base, in tie-break order
	typedef enum logic [1:0] {
		BASE_A = 2'd0,
		BASE_T = 2'd1,
		BASE_G = 2'd2,
		BASE_C = 2'd3
	} base_t;

	typedef struct packed {
		logic  hit;
		base_t code;
	} nuc_t;

	// result word, first field in the high bits
	typedef struct packed {
		logic [CNT_W-1:0] depth;
		logic [CNT_W-1:0] support;
		logic [GAP_W-1:0] gaps_before;
		base_t            base_code;
	} call_t;

	function automatic nuc_t decode_char(input logic [CHAR_W-1:0] ch);
		nuc_t r;
		r.hit  = 1'b1;
		r.code = BASE_A;
		unique case (ch)
			8'h41, 8'h61: r.code = BASE_A;
			8'h54, 8'h74: r.code = BASE_T;
			8'h47, 8'h67: r.code = BASE_G;
			8'h43, 8'h63: r.code = BASE_C;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pileup_consensus_caller_unit.sv =====
// pileup majority-vote consensus caller, top level
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata cell_char, tlast column_end,
//                                             tuser contig_start
// m_axis    out  m_axis_tvalid/tready        tdata base_code, gaps_before,
//                                             support, depth
// cfg       in   cfg_valid/cfg_ready         cfg_data min_support
//
// one word per cycle while no held result stalls the input; a word is registered in
// the input register, and the call that a column end makes in the result register
// the count update, argmax and threshold compare sit between those registers
// async reset clears counters, contig state, min_support and both valids
// a held result stalls the input register, which then stalls s_axis
module pileup_consensus_caller_unit #(
	parameter int unsigned MAX_READS = 256,
	parameter int unsigned MAX_GAP   = 4095
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [pcc_pkg::CHAR_W-1:0]    s_axis_tdata,   // [7:0] cell_char
	input  wire                           s_axis_tlast,   // column_end
	input  wire                           s_axis_tuser,   // contig_start
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	// [1:0] base_code, [13:2] gaps_before, [22:14] support, [31:23] depth
	output logic [pcc_pkg::OUT_W-1:0]     m_axis_tdata,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [pcc_pkg::CNT_W-1:0]     cfg_data        // min_support
);

	import pcc_pkg::*;

	// saturation limits
	localparam int unsigned CNT_CAP_I = (MAX_READS < 511) ? MAX_READS : 511;
	localparam int unsigned GAP_CAP_I = (MAX_GAP < 4095) ? MAX_GAP : 4095;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);
	localparam logic [GAP_W-1:0] GAP_CAP = GAP_W'(GAP_CAP_I);

	// configuration
	logic [CNT_W-1:0] min_support_q;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              start_s1;

	// column and contig state
	logic [CNT_W-1:0] base_counts_q [NUM_BASES];
	logic [CNT_W-1:0] column_depth_q;
	logic             started_q;
	logic [GAP_W-1:0] gaps_q;

	// result register
	logic  m_valid_q;
	call_t m_data_q;

	// stage two combinational work
	logic             out_free;
	logic             advance;
	nuc_t             nuc;
	logic [CNT_W-1:0] cnt_nx [NUM_BASES];
	logic [CNT_W-1:0] depth_nx;
	base_t            best;
	logic [CNT_W-1:0] best_cnt;
	logic             started_eff;
	logic [GAP_W-1:0] gaps_eff;
	logic [CNT_W+1:0] lhs4;
	logic [CNT_W+1:0] rhs3;
	logic             do_call;

	assign cfg_ready     = 1'b1;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_comb begin
		nuc = decode_char(char_s1);
		for (int i = 0; i < NUM_BASES; i++) begin
			cnt_nx[i] = base_counts_q[i];
			if (nuc.hit && (nuc.code == base_t'(i)) && (base_counts_q[i] < CNT_CAP)) begin
				cnt_nx[i] = base_counts_q[i] + 1'b1;
			end
		end
		depth_nx = column_depth_q;
		if (nuc.hit && (column_depth_q < CNT_CAP)) begin
			depth_nx = column_depth_q + 1'b1;
		end

		// argmax, ties to the earlier base
		best     = BASE_A;
		best_cnt = cnt_nx[0];
		for (int i = 1; i < NUM_BASES; i++) begin
			if (cnt_nx[i] > best_cnt) begin
				best     = base_t'(i);
				best_cnt = cnt_nx[i];
			end
		end

		// 4*count > 3*depth
		lhs4    = {best_cnt, 2'b00};
		rhs3    = {1'b0, depth_nx, 1'b0} + {2'b00, depth_nx};
		do_call = last_s1 && (best_cnt > min_support_q) && (lhs4 > rhs3);

		// contig start clears before the cell counts
		started_eff = start_s1 ? 1'b0 : started_q;
		gaps_eff    = start_s1 ? '0 : gaps_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_support_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_support_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			start_s1 <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASES; i++) begin
				base_counts_q[i] <= '0;
			end
			column_depth_q <= '0;
			started_q      <= 1'b0;
			gaps_q         <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_BASES; i++) begin
				base_counts_q[i] <= last_s1 ? '0 : cnt_nx[i];
			end
			column_depth_q <= last_s1 ? '0 : depth_nx;
			priority if (do_call) begin
				started_q <= 1'b1;
				gaps_q    <= '0;
			end else if (last_s1 && started_eff && (gaps_eff < GAP_CAP)) begin
				started_q <= started_eff;
				gaps_q    <= gaps_eff + 1'b1;
			end else begin
				started_q <= started_eff;
				gaps_q    <= gaps_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= advance && do_call;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && do_call) begin
			m_data_q.base_code   <= best;
			m_data_q.gaps_before <= gaps_eff;
			m_data_q.support     <= best_cnt;
			m_data_q.depth       <= depth_nx;
		end
	end

endmodule

`default_nettype wire
